@@ hdl/mms_pkg.sv @@
// Package for the min-max scaler: sizes, item structs and sequencer states.
// No dependencies; imported by min_max_scaler_core and mms_divider.
`timescale 1ns / 1ps
`default_nettype none
package mms_pkg;

  localparam int DEPTH         = 64;
  localparam int SAMPLE_BITS   = 16;
  localparam int FRACTION_BITS = 16;

  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int QUOT_W  = FRACTION_BITS + 1;
  localparam int STEP_W  = $clog2(QUOT_W);
  localparam int REM_W   = SAMPLE_BITS + 1;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last_sample;
  } in_item_t;

  typedef struct packed {
    logic [QUOT_W-1:0]             scaled_value;
    logic signed [SAMPLE_BITS-1:0] original_value;
    logic                          flat_series;
    logic                          last_result;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CALC,
    S_DIV,
    S_EMIT
  } state_t;

endpackage
`default_nettype wire

@@ hdl/min_max_scaler_core.sv @@
// Min-max scaler top level: load sequencer, sample store and shared divider.
// Depends on mms_pkg, mms_ram and mms_divider.
//
// Samples are taken one per item (start high while busy is low) and
// stored in a 64-entry RAM while the running minimum and maximum are
// kept. Samples beyond 64 are dropped. The item with last_sample set ends the
// series: busy rises and every stored sample is emitted in arrival order as
// (x - min) * 65536 / (max - min), truncated, with the original sample beside
// it. Each result is shown for exactly one cycle with strobe high; there is
// no backpressure, so the receiver must take it then. Each result passes
// through one RAM read, a step that forms the difference and starts the
// divider, the bit-serial divider (17 quotient bits, one a cycle, then its
// registered done) and the output state S_EMIT. A flat series (max equals
// min) skips the divider, with scaled_value 0 and flat_series set. After the
// final result busy falls and the store is empty again.
`timescale 1ns / 1ps
`default_nettype none
module min_max_scaler_core
  import mms_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  input  wire in_item_t  item,
  output logic           busy,
  output logic           strobe,
  output out_item_t      result
);

  state_t state;
  state_t state_next;

  logic                          accept;
  logic [CNT_W-1:0]              count;
  logic [ADDR_W-1:0]             idx;
  logic signed [SAMPLE_BITS-1:0] run_min;
  logic signed [SAMPLE_BITS-1:0] run_max;
  logic                          room;
  logic                          idx_last;

  logic                          ram_re;
  logic [SAMPLE_BITS-1:0]        ram_rdata;
  logic                          div_go;
  logic                          div_done;
  logic [QUOT_W-1:0]             quotient;

  logic [SAMPLE_BITS:0]          range_full;
  logic [SAMPLE_BITS:0]          diff_full;
  logic                          flat;

  assign accept   = start && !busy;
  assign room     = (count != CNT_W'(DEPTH));
  assign idx_last = ((CNT_W'(idx) + CNT_W'(1)) == count);

  // max - min and x - min never go negative, so the low bits are exact
  assign range_full = {run_max[SAMPLE_BITS-1], run_max} - {run_min[SAMPLE_BITS-1], run_min};
  assign diff_full  = {ram_rdata[SAMPLE_BITS-1], ram_rdata}
                    - {run_min[SAMPLE_BITS-1], run_min};
  assign flat       = (range_full[SAMPLE_BITS-1:0] == '0);

  mms_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (accept && room),
    .waddr(count[ADDR_W-1:0]),
    .wdata(item.sample),
    .re   (ram_re),
    .raddr(idx),
    .rdata(ram_rdata)
  );

  mms_divider u_div (
    .clk     (clk),
    .rst     (rst),
    .go      (div_go),
    .diff    (diff_full[SAMPLE_BITS-1:0]),
    .range   (range_full[SAMPLE_BITS-1:0]),
    .done    (div_done),
    .quotient(quotient)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && item.last_sample) state_next = S_READ;
      end
      S_READ: begin
        state_next = S_CALC;
      end
      S_CALC: begin
        state_next = flat ? S_EMIT : S_DIV;
      end
      S_DIV: begin
        if (div_done) state_next = S_EMIT;
      end
      S_EMIT: begin
        state_next = idx_last ? S_IDLE : S_READ;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    busy   = (state != S_IDLE);
    ram_re = (state == S_READ);
    div_go = (state == S_CALC) && !flat;
    strobe = (state == S_EMIT);
  end

  // result fields are formed combinationally from registers held through S_EMIT
  always_comb begin
    result.scaled_value   = flat ? '0 : quotient;
    result.original_value = ram_rdata;
    result.flat_series    = flat;
    result.last_result    = idx_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      idx   <= '0;
    end else begin
      state <= state_next;
      if (accept && room) begin
        count <= count + CNT_W'(1);
      end
      if (accept) begin
        idx <= '0;
      end else if (state == S_EMIT) begin
        if (idx_last) begin
          count <= '0;
        end else begin
          idx <= idx + ADDR_W'(1);
        end
      end
    end
  end

  // first sample of a series loads both bounds
  always_ff @(posedge clk) begin
    if (accept && room) begin
      if (count == '0) begin
        run_min <= item.sample;
        run_max <= item.sample;
      end else begin
        if (item.sample < run_min) run_min <= item.sample;
        if (item.sample > run_max) run_max <= item.sample;
      end
    end
  end

endmodule
`default_nettype wire

@@ hdl/mms_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module mms_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ hdl/mms_divider.sv @@
// Restoring divider: (diff * 2^FRACTION_BITS) / range, one quotient bit a cycle.
// Depends on mms_pkg; requires diff <= range.
`timescale 1ns / 1ps
`default_nettype none
module mms_divider
  import mms_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   go,
  input  wire logic [SAMPLE_BITS-1:0] diff,
  input  wire logic [SAMPLE_BITS-1:0] range,
  output logic                        done,
  output logic [QUOT_W-1:0]           quotient
);

  logic [REM_W-1:0]       rem;
  logic [SAMPLE_BITS-1:0] divisor;
  logic [STEP_W-1:0]      step;
  logic                   running;
  logic [REM_W-1:0]       trial;
  logic                   fits;

  // first step compares diff as is (integer quotient bit), later ones shift
  always_comb begin
    trial = (step == '0) ? rem : {rem[REM_W-2:0], 1'b0};
    fits  = (trial >= {1'b0, divisor});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        running <= 1'b1;
      end else if (running && step == STEP_W'(QUOT_W - 1)) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rem      <= {1'b0, diff};
      divisor  <= range;
      step     <= '0;
      quotient <= '0;
    end else if (running) begin
      rem      <= fits ? (trial - {1'b0, divisor}) : trial;
      quotient <= {quotient[QUOT_W-2:0], fits};
      step     <= step + STEP_W'(1);
    end
  end

endmodule
`default_nettype wire
